// ===== rtl/tps_pkg.sv =====
// Shared types and constants for the tone pattern sequencer.
// Used by every module in rtl/; has no dependencies of its own.
`timescale 1ns / 1ps

package tps_pkg;

  // Field widths of one beat
  localparam int unsigned ReqW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FreqW  = 20;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned MsW    = 32;
  localparam int unsigned ActW   = 2;

  localparam logic [DutyW-1:0] DUTY_MAX   = 7'd100;
  localparam logic [ByteW-1:0] IDLE_INDEX = 8'hFF;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_WRITE_STEP = 3'd0,
    REQ_WRITE_PAT  = 3'd1,
    REQ_LOAD       = 3'd2,
    REQ_TICK       = 3'd3,
    REQ_STOP       = 3'd4,
    REQ_FREQ_OVR   = 3'd5,
    REQ_DUTY_OVR   = 3'd6,
    REQ_CLEAR_OVR  = 3'd7
  } req_e;

  // PWM command codes
  typedef enum logic [ActW-1:0] {
    ACT_NONE   = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_RECONF = 2'd2
  } act_e;

  // What the result stage still has to do with a beat
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_APPLY  = 2'd2,
    KIND_RECONF = 2'd3
  } kind_e;

  // One step memory word
  typedef struct packed {
    logic [FreqW-1:0] freq;
    logic [DutyW-1:0] duty;
    logic [TimeW-1:0] dur;
  } step_t;

  // One pattern descriptor
  typedef struct packed {
    logic [ByteW-1:0] base;
    logic [ByteW-1:0] count;
    logic [ByteW-1:0] loops;
  } desc_t;

  // One input beat
  typedef struct packed {
    req_e             req_type;
    logic [ByteW-1:0] pattern_number;
    logic [ByteW-1:0] step_address;
    logic [ByteW-1:0] step_total;
    logic [ByteW-1:0] loop_total;
    logic [FreqW-1:0] freq_hz;
    logic [DutyW-1:0] duty_level;
    logic [TimeW-1:0] hold_ms;
    logic [MsW-1:0]   now_ms;
  } req_t;

  // Beat handed from the execute stage to the result stage
  typedef struct packed {
    kind_e            kind;
    logic [FreqW-1:0] freq;
    logic [DutyW-1:0] duty;
    logic             running;
    logic [ByteW-1:0] index;
    logic             load_ok;
    logic             fov_on;
    logic [FreqW-1:0] fov;
    logic             dov_on;
    logic [DutyW-1:0] dov;
  } pend_t;

endpackage

// ===== rtl/tps_step_mem.sv =====
// Step memory: one write port, one read port with registered read data.
// Depends on tps_pkg for the step word type.
`timescale 1ns / 1ps

module tps_step_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  tps_pkg::step_t             wdata_i,
  input  logic [tps_pkg::ByteW-1:0]  raddr_i,
  output tps_pkg::step_t             rdata_o
);

  tps_pkg::step_t mem [DEPTH];
  tps_pkg::step_t rdata_q;
  logic           rd_in;

  assign rd_in = {1'b0, raddr_i} < (tps_pkg::ByteW + 1)'(DEPTH);

  // Write the addressed word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read with new data on a same-address write; outside the memory reads as zero
  always_ff @(posedge clk_i) begin
    if (!rd_in) begin
      rdata_q <= '0;
    end else if (we_i && (waddr_i == raddr_i[AW-1:0])) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tps_exec.sv =====
// Execute stage: sequencer state, descriptor table and step memory control.
// Depends on tps_pkg; drives the step memory ports and the pending beat.
`timescale 1ns / 1ps

module tps_exec #(
  parameter int unsigned PATTERN_SLOTS = 16,
  parameter int unsigned STEP_DEPTH    = 256,
  parameter int unsigned SLW           = 4,
  parameter int unsigned SAW           = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  tps_pkg::req_t              req_i,
  input  tps_pkg::step_t             cur_step_i,
  output logic                       mem_we_o,
  output logic [SAW-1:0]             mem_waddr_o,
  output tps_pkg::step_t             mem_wdata_o,
  output logic [tps_pkg::ByteW-1:0]  mem_raddr_o,
  output tps_pkg::pend_t             pend_o
);

  localparam int unsigned BW = tps_pkg::ByteW;

  tps_pkg::desc_t            desc_q [PATTERN_SLOTS];
  tps_pkg::desc_t            act_desc_q, act_desc_d;
  logic                      active_q, active_d;
  logic [SLW-1:0]            apat_q, apat_d;
  logic [BW-1:0]             pos_q, pos_d;
  logic [BW-1:0]             loop_q, loop_d;
  logic [tps_pkg::MsW-1:0]   begin_q, begin_d;
  logic                      fov_on_q, fov_on_d;
  logic [tps_pkg::FreqW-1:0] fov_q, fov_d;
  logic                      dov_on_q, dov_on_d;
  logic [tps_pkg::DutyW-1:0] dov_q, dov_d;

  logic                      desc_we;
  logic [SLW-1:0]            psel;
  logic                      pnum_ok;
  logic                      use_req;
  tps_pkg::desc_t            desc_new;
  tps_pkg::desc_t            load_desc;
  logic [tps_pkg::DutyW-1:0] duty_c;
  logic [tps_pkg::MsW-1:0]   elapsed;
  logic [BW:0]               pos_inc;
  logic [BW:0]               loop_inc;
  tps_pkg::pend_t            pend;

  assign psel    = req_i.pattern_number[SLW-1:0];
  assign pnum_ok = {1'b0, req_i.pattern_number} < (BW + 1)'(PATTERN_SLOTS);
  assign duty_c  = (req_i.duty_level > tps_pkg::DUTY_MAX) ? tps_pkg::DUTY_MAX
                                                          : req_i.duty_level;
  assign elapsed = req_i.now_ms - begin_q;
  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign loop_inc = {1'b0, loop_q} + 1'b1;

  assign desc_new = '{base: req_i.step_address, count: req_i.step_total,
                      loops: req_i.loop_total};

  // Pick the requested pattern, or fall back to pattern 0
  assign use_req   = pnum_ok && (desc_q[psel].count != '0);
  assign load_desc = use_req ? desc_q[psel] : desc_q[0];

  // Next state and pending beat
  always_comb begin
    act_desc_d  = act_desc_q;
    active_d    = active_q;
    apat_d      = apat_q;
    pos_d       = pos_q;
    loop_d      = loop_q;
    begin_d     = begin_q;
    fov_on_d    = fov_on_q;
    fov_d       = fov_q;
    dov_on_d    = dov_on_q;
    dov_d       = dov_q;
    desc_we     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = req_i.step_address[SAW-1:0];
    mem_wdata_o = '{freq: req_i.freq_hz, duty: duty_c, dur: req_i.hold_ms};
    pend        = '0;
    pend.kind   = tps_pkg::KIND_NONE;

    if (fire_i) begin
      case (req_i.req_type)
        tps_pkg::REQ_WRITE_STEP: begin
          mem_we_o = {1'b0, req_i.step_address} < (BW + 1)'(STEP_DEPTH);
        end
        tps_pkg::REQ_WRITE_PAT: begin
          if (pnum_ok) begin
            desc_we = 1'b1;
            if (req_i.pattern_number == BW'(apat_q)) begin
              act_desc_d = desc_new;
            end
          end
        end
        tps_pkg::REQ_LOAD: begin
          if (load_desc.count != '0) begin
            apat_d       = use_req ? psel : '0;
            act_desc_d   = load_desc;
            pos_d        = '0;
            loop_d       = '0;
            begin_d      = '0;
            active_d     = 1'b1;
            pend.kind    = tps_pkg::KIND_APPLY;
            pend.load_ok = 1'b1;
          end
        end
        tps_pkg::REQ_TICK: begin
          if (active_q && (elapsed >= {16'd0, cur_step_i.dur})) begin
            // Advance the step; wrap at the end of the pattern and count a loop if a loop total is set
            pos_d = pos_inc[BW-1:0];
            if (pos_inc >= {1'b0, act_desc_q.count}) begin
              pos_d = '0;
              if (act_desc_q.loops != '0) begin
                loop_d = loop_inc[BW-1:0];
              end
            end
            if ((pos_inc >= {1'b0, act_desc_q.count}) && (act_desc_q.loops != '0) &&
                (loop_inc >= {1'b0, act_desc_q.loops})) begin
              active_d  = 1'b0;
              pend.kind = tps_pkg::KIND_STOP;
            end else begin
              begin_d   = req_i.now_ms;
              pend.kind = tps_pkg::KIND_APPLY;
            end
          end
        end
        tps_pkg::REQ_STOP: begin
          active_d  = 1'b0;
          pend.kind = tps_pkg::KIND_STOP;
        end
        tps_pkg::REQ_FREQ_OVR: begin
          fov_on_d = 1'b1;
          fov_d    = req_i.freq_hz;
          if (active_q) begin
            pend.kind = tps_pkg::KIND_RECONF;
            pend.freq = req_i.freq_hz;
            pend.duty = dov_on_q ? dov_q : cur_step_i.duty;
          end
        end
        tps_pkg::REQ_DUTY_OVR: begin
          dov_on_d = 1'b1;
          dov_d    = duty_c;
          if (active_q) begin
            pend.kind = tps_pkg::KIND_RECONF;
            pend.freq = fov_on_q ? fov_q : cur_step_i.freq;
            pend.duty = duty_c;
          end
        end
        default: begin
          fov_on_d = 1'b0;
          dov_on_d = 1'b0;
        end
      endcase
    end

    pend.running = active_d;
    pend.index   = active_d ? BW'(apat_d) : tps_pkg::IDLE_INDEX;
    pend.fov_on  = fov_on_d;
    pend.fov     = fov_d;
    pend.dov_on  = dov_on_d;
    pend.dov     = dov_d;
  end

  // Read the step the state will point at after this beat
  assign mem_raddr_o = act_desc_d.base + pos_d;
  assign pend_o      = pend;

  // Hold the descriptor table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
        desc_q[i] <= '0;
      end
    end else if (desc_we) begin
      desc_q[psel] <= desc_new;
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_desc_q <= '0;
      active_q   <= 1'b0;
      apat_q     <= '0;
      pos_q      <= '0;
      loop_q     <= '0;
      begin_q    <= '0;
      fov_on_q   <= 1'b0;
      fov_q      <= '0;
      dov_on_q   <= 1'b0;
      dov_q      <= '0;
    end else begin
      act_desc_q <= act_desc_d;
      active_q   <= active_d;
      apat_q     <= apat_d;
      pos_q      <= pos_d;
      loop_q     <= loop_d;
      begin_q    <= begin_d;
      fov_on_q   <= fov_on_d;
      fov_q      <= fov_d;
      dov_on_q   <= dov_on_d;
      dov_q      <= dov_d;
    end
  end

endmodule

// ===== rtl/tps_resolve.sv =====
// Result stage: pending beat register, step-data merge and output register.
// Depends on tps_pkg; takes the registered step memory read data.
`timescale 1ns / 1ps

module tps_resolve (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pend_load_i,
  input  tps_pkg::pend_t              pend_i,
  output logic                        pend_ready_o,
  input  tps_pkg::step_t              step_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tps_pkg::ActW-1:0]    pwm_action_o,
  output logic [tps_pkg::FreqW-1:0]   pwm_freq_o,
  output logic [tps_pkg::DutyW-1:0]   pwm_duty_o,
  output logic                        running_o,
  output logic [tps_pkg::ByteW-1:0]   playing_index_o,
  output logic                        load_ok_o
);

  logic                      pend_valid_q;
  tps_pkg::pend_t            pend_q;
  logic                      out_valid_q;
  logic                      out_can;
  tps_pkg::act_e             act_d, act_q;
  logic [tps_pkg::FreqW-1:0] freq_d, freq_q;
  logic [tps_pkg::DutyW-1:0] duty_d, duty_q;
  logic                      running_q;
  logic [tps_pkg::ByteW-1:0] index_q;
  logic                      ok_q;

  assign out_can      = !out_valid_q || !out_stall_i;
  assign pend_ready_o = !pend_valid_q || out_can;

  // Merge the pending beat with the step it now points at
  always_comb begin
    act_d  = tps_pkg::ACT_NONE;
    freq_d = '0;
    duty_d = '0;
    case (pend_q.kind)
      tps_pkg::KIND_STOP: begin
        act_d = tps_pkg::ACT_STOP;
      end
      tps_pkg::KIND_APPLY: begin
        if (step_i.freq == '0) begin
          act_d = tps_pkg::ACT_STOP;
        end else begin
          act_d  = tps_pkg::ACT_RECONF;
          freq_d = pend_q.fov_on ? pend_q.fov : step_i.freq;
          duty_d = pend_q.dov_on ? pend_q.dov : step_i.duty;
        end
      end
      tps_pkg::KIND_RECONF: begin
        act_d  = tps_pkg::ACT_RECONF;
        freq_d = pend_q.freq;
        duty_d = pend_q.duty;
      end
      default: begin
        act_d = tps_pkg::ACT_NONE;
      end
    endcase
  end

  // Advance the pending beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (pend_ready_o) begin
      pend_valid_q <= pend_load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_ready_o && pend_load_i) begin
      pend_q <= pend_i;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_can) begin
      out_valid_q <= pend_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_can && pend_valid_q) begin
      act_q     <= act_d;
      freq_q    <= freq_d;
      duty_q    <= duty_d;
      running_q <= pend_q.running;
      index_q   <= pend_q.index;
      ok_q      <= pend_q.load_ok;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pwm_action_o    = act_q;
  assign pwm_freq_o      = freq_q;
  assign pwm_duty_o      = duty_q;
  assign running_o       = running_q;
  assign playing_index_o = index_q;
  assign load_ok_o       = ok_q;

endmodule

// ===== rtl/tone_pattern_sequencer.sv =====
// Tone pattern sequencer top level: input register, execute and result stages.
// Depends on tps_pkg, tps_step_mem, tps_exec and tps_resolve.
//
// Usage:
//   Input channel in_valid_i/in_stall_o carries one request beat (step or
//   descriptor write, load, tick, stop, overrides). Output channel
//   out_valid_o/out_stall_i returns exactly one result beat per request:
//   the PWM command, running flag, playing index (255 when idle), load_ok.
//   A beat is taken at a clock edge where valid is high and stall is low.
//   From the accepting edge to out_valid_o rising, a beat passes the input
//   register, then the execute stage with its state update and step
//   memory read, then the result stage merging the read step word into the
//   PWM command and writing the output register.
//   Throughput is one beat per cycle when out_stall_i is low; the registered
//   step memory read runs alongside the next beat's execute.
//   Reset (rst_ni low) clears the sequencer state and all descriptors; the
//   step memory holds nothing defined until it is written.
//   When the receiver stalls, the result stays in the output register, one
//   more beat waits in the result stage, one in the input register, and
//   then in_stall_o rises.
`timescale 1ns / 1ps

module tone_pattern_sequencer #(
  parameter int unsigned PATTERN_SLOTS = 16,
  parameter int unsigned STEP_DEPTH    = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tps_pkg::ReqW-1:0]    req_type_i,
  input  logic [tps_pkg::ByteW-1:0]   pattern_number_i,
  input  logic [tps_pkg::ByteW-1:0]   step_address_i,
  input  logic [tps_pkg::ByteW-1:0]   step_total_i,
  input  logic [tps_pkg::ByteW-1:0]   loop_total_i,
  input  logic [tps_pkg::FreqW-1:0]   freq_hz_i,
  input  logic [tps_pkg::DutyW-1:0]   duty_level_i,
  input  logic [tps_pkg::TimeW-1:0]   hold_ms_i,
  input  logic [tps_pkg::MsW-1:0]     now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tps_pkg::ActW-1:0]    pwm_action_o,
  output logic [tps_pkg::FreqW-1:0]   pwm_freq_o,
  output logic [tps_pkg::DutyW-1:0]   pwm_duty_o,
  output logic                        running_o,
  output logic [tps_pkg::ByteW-1:0]   playing_index_o,
  output logic                        load_ok_o
);

  localparam int unsigned SLW = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int unsigned SAW = $clog2(STEP_DEPTH);

  logic                      in_valid_q;
  tps_pkg::req_t             in_q;
  logic                      in_accept;
  logic                      exec_fire;
  logic                      pend_ready;
  tps_pkg::pend_t            pend;
  tps_pkg::step_t            step_rd;
  logic                      mem_we;
  logic [SAW-1:0]            mem_waddr;
  tps_pkg::step_t            mem_wdata;
  logic [tps_pkg::ByteW-1:0] mem_raddr;

  assign exec_fire  = in_valid_q && pend_ready;
  assign in_stall_o = in_valid_q && !exec_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Capture the request beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (exec_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.req_type       <= tps_pkg::req_e'(req_type_i);
      in_q.pattern_number <= pattern_number_i;
      in_q.step_address   <= step_address_i;
      in_q.step_total     <= step_total_i;
      in_q.loop_total     <= loop_total_i;
      in_q.freq_hz        <= freq_hz_i;
      in_q.duty_level     <= duty_level_i;
      in_q.hold_ms        <= hold_ms_i;
      in_q.now_ms         <= now_ms_i;
    end
  end

  tps_step_mem #(
    .DEPTH (STEP_DEPTH),
    .AW    (SAW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (step_rd)
  );

  tps_exec #(
    .PATTERN_SLOTS (PATTERN_SLOTS),
    .STEP_DEPTH    (STEP_DEPTH),
    .SLW           (SLW),
    .SAW           (SAW)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (exec_fire),
    .req_i       (in_q),
    .cur_step_i  (step_rd),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .pend_o      (pend)
  );

  tps_resolve u_resolve (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pend_load_i     (exec_fire),
    .pend_i          (pend),
    .pend_ready_o    (pend_ready),
    .step_i          (step_rd),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pwm_action_o    (pwm_action_o),
    .pwm_freq_o      (pwm_freq_o),
    .pwm_duty_o      (pwm_duty_o),
    .running_o       (running_o),
    .playing_index_o (playing_index_o),
    .load_ok_o       (load_ok_o)
  );

  // A successful load always leaves a pattern playing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && load_ok_o) |-> running_o)
    else $error("load_ok without a running pattern");

  // Idle results report the idle index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !running_o) |-> (playing_index_o == tps_pkg::IDLE_INDEX))
    else $error("idle result with a pattern index");

  // Frequency and duty only travel with a reconfigure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (pwm_action_o != tps_pkg::ACT_RECONF)) |->
      ((pwm_freq_o == '0) && (pwm_duty_o == '0)))
    else $error("PWM values on a non-reconfigure result");

  // Duty never leaves the percent range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pwm_duty_o <= tps_pkg::DUTY_MAX))
    else $error("duty above 100 percent");

  // A waiting request beat holds while the later stages are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !exec_fire) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled request beat lost");

endmodule
